[design/wms_pkg.sv]
// shared constants and the interpolation helper for the wavetable morph shaper
// no dependencies
package wms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MORPH_W  = 17;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SHAPE = 1'b1;

  // a + trunc((b-a)*f/65536), truncation toward zero
  function automatic logic signed [SAMPLE_W-1:0] lerp_q16(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [FRAC_W-1:0] f
  );
    logic signed [SAMPLE_W:0]     diff;
    logic signed [2*SAMPLE_W+1:0] prod;
    logic signed [2*SAMPLE_W+1:0] adj;
    logic signed [SAMPLE_W:0]     step;
    diff = (SAMPLE_W+1)'(b) - (SAMPLE_W+1)'(a);
    prod = diff * $signed({1'b0, f});
    adj  = prod[2*SAMPLE_W+1] ? prod + (2*SAMPLE_W+2)'(65535) : prod;
    step = adj[FRAC_W+SAMPLE_W:FRAC_W];
    return SAMPLE_W'((SAMPLE_W+1)'(a) + step);
  endfunction

endpackage

[design/wms_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module wms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/wms_front.sv]
// front end: classifies an input beat and works out bank indexes and fractions
// uses wms_pkg
module wms_front #(
  parameter int TABLE_SIZE = 1024,
  parameter int MAX_FRAMES = 8,
  parameter int FIW        = 3,
  parameter int EIW        = 10,
  parameter int QW         = 80
) (
  input  logic                          op,
  input  logic [2:0]                    frame_sel,
  input  logic [9:0]                    entry_sel,
  input  logic signed [15:0]            entry_value,
  input  logic signed [15:0]            sample_in,
  input  logic [16:0]                   morph,
  input  logic [6:0]                    nf,
  output logic [QW-1:0]                 q_word
);

  localparam int TW = $clog2(TABLE_SIZE + 1);
  localparam int EQW = wms_pkg::SAMPLE_W + TW;

  logic [16:0]     m_c;
  logic [6:0]      top_frame;
  logic [23:0]     p;
  logic [7:0]      flo;
  logic [7:0]      flo_c;
  logic            fpair;
  logic [15:0]     u;
  logic [EQW-1:0]  q;
  logic [EQW-17:0] elo;
  logic [EQW-17:0] elo_c;
  logic            epair;
  logic            wvalid;
  logic            fpar;
  logic            epar;
  logic [FIW-1:0]  fi0, fi1;
  logic [EIW-1:0]  ei0, ei1;
  logic [15:0]     data;
  logic [15:0]     ff, ef;

  always_comb begin
    m_c       = (morph > 17'd65536) ? 17'd65536 : morph;
    top_frame = nf - 7'd1;
    p         = 24'(m_c) * 24'(top_frame);
    flo       = p[23:16];
    fpair     = flo < 8'(top_frame);
    flo_c     = fpair ? flo : 8'(top_frame);
    u         = {~sample_in[15], sample_in[14:0]};
    q         = EQW'(u) * EQW'(TABLE_SIZE);
    elo       = q[EQW-1:16];
    epair     = elo < (EQW-16)'(TABLE_SIZE - 1);
    elo_c     = epair ? elo : (EQW-16)'(TABLE_SIZE - 1);
    wvalid    = (32'(frame_sel) < MAX_FRAMES) && (32'(entry_sel) < TABLE_SIZE);
    if (op == wms_pkg::OP_SHAPE) begin
      fpar = flo_c[0];
      epar = elo_c[0];
      fi0  = FIW'((9'(flo_c) + 9'd1) >> 1);
      fi1  = FIW'(flo_c >> 1);
      ei0  = EIW'(((EQW-15)'(elo_c) + (EQW-15)'(1)) >> 1);
      ei1  = EIW'(elo_c >> 1);
      data = sample_in;
    end else begin
      fpar = frame_sel[0];
      epar = entry_sel[0];
      fi0  = FIW'(frame_sel >> 1);
      fi1  = FIW'(frame_sel >> 1);
      ei0  = EIW'(entry_sel >> 1);
      ei1  = EIW'(entry_sel >> 1);
      data = entry_value;
    end
    ff = p[15:0];
    ef = q[15:0];
  end

  assign q_word = {op, wvalid, fpar, epar, fi0, fi1, ei0, ei1, data, ff, ef, fpair, epair};

endmodule

[design/wms_queue.sv]
// two-entry queue between the front end and the back end
// no dependencies
module wms_queue #(
  parameter int W = 80
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         nonempty,
  output logic [W-1:0] head
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  assign full     = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign head     = slot_r[rp_r];

endmodule

[design/wms_back.sv]
// back end: four parity banks, frame lerp, entry lerp, output register
// uses wms_pkg and wms_ram
module wms_back #(
  parameter int TABLE_SIZE = 1024,
  parameter int MAX_FRAMES = 8,
  parameter int FIW        = 3,
  parameter int EIW        = 10,
  parameter int QW         = 80
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  logic [QW-1:0]      q_head,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata
);

  localparam int FHALF = (MAX_FRAMES + 1) / 2;
  localparam int EHALF = (TABLE_SIZE + 1) / 2;
  localparam int DEPTH = FHALF * EHALF;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic           op, wvalid, fpar, epar, fpair, epair;
  logic [FIW-1:0] fi0, fi1;
  logic [EIW-1:0] ei0, ei1;
  logic [15:0]    data, ff, ef;
  logic           en;
  logic           shape;
  logic [15:0]    rd [4];

  logic           s1_valid_r;
  logic           s1_fpar_r, s1_epar_r, s1_fpair_r, s1_epair_r;
  logic [15:0]    s1_ff_r, s1_ef_r;
  logic           s2_valid_r;
  logic           s2_epair_r;
  logic [15:0]    s2_ef_r;
  logic signed [15:0] s2_lo_r, s2_hi_r;
  logic           out_valid_r;
  logic signed [15:0] out_data_r;

  logic signed [15:0] a_lo, b_lo, a_hi, b_hi, v_lo, v_hi, res;

  assign {op, wvalid, fpar, epar, fi0, fi1, ei0, ei1, data, ff, ef, fpair, epair} = q_head;

  // whole back pipe moves together when the output slot frees
  assign en    = out_tready || !out_valid_r;
  assign q_pop = en && q_nonempty;
  assign shape = q_nonempty && (op == wms_pkg::OP_SHAPE);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [FIW-1:0] rfi;
    logic [EIW-1:0] rei;
    always_comb begin
      we    = q_pop && (op == wms_pkg::OP_WRITE) && wvalid &&
              (fpar == b[1]) && (epar == b[0]);
      waddr = AW'(AW'(fi0) * AW'(EHALF) + AW'(ei0));
      rfi   = b[1] ? fi1 : fi0;
      rei   = b[0] ? ei1 : ei0;
      raddr = AW'(AW'(rfi) * AW'(EHALF) + AW'(rei));
    end
    wms_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (data),
      .re    (en),
      .raddr (raddr),
      .rdata (rd[b])
    );
  end

  // bank index is {frame parity, entry parity}
  always_comb begin
    a_lo = rd[{s1_fpar_r, s1_epar_r}];
    b_lo = rd[{~s1_fpar_r, s1_epar_r}];
    a_hi = rd[{s1_fpar_r, ~s1_epar_r}];
    b_hi = rd[{~s1_fpar_r, ~s1_epar_r}];
    v_lo = s1_fpair_r ? wms_pkg::lerp_q16(a_lo, b_lo, s1_ff_r) : a_lo;
    v_hi = s1_fpair_r ? wms_pkg::lerp_q16(a_hi, b_hi, s1_ff_r) : a_hi;
    res  = s2_epair_r ? wms_pkg::lerp_q16(s2_lo_r, s2_hi_r, s2_ef_r) : s2_lo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= shape;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
    if (en) begin
      s1_fpar_r  <= fpar;
      s1_epar_r  <= epar;
      s1_fpair_r <= fpair;
      s1_epair_r <= epair;
      s1_ff_r    <= ff;
      s1_ef_r    <= ef;
      s2_lo_r    <= v_lo;
      s2_hi_r    <= v_hi;
      s2_ef_r    <= s1_ef_r;
      s2_epair_r <= s1_epair_r;
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[design/wavetable_morph_shaper.sv]
// wavetable morph shaper: frame and entry interpolation over a stored curve bank
// throughput one beat per cycle unless out_tready stalls the back pipe
// the table is split into four parity banks so all four corner points read at once
// shape results pass the queue, s1, s2 and output regs; write beats give no result
// reset clears control state and sets frames_in_use to 2; table contents stay undefined
// uses wms_pkg, wms_front, wms_queue, wms_back
module wavetable_morph_shaper #(
  parameter int TABLE_SIZE = 1024,
  parameter int MAX_FRAMES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // frame_sel[2:0], entry_sel[12:3], entry_value[28:13], sample_in[44:29], morph[61:45]
  input  logic [63:0] in_tdata,
  // op[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sample_out[15:0]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int FHALF = (MAX_FRAMES + 1) / 2;
  localparam int EHALF = (TABLE_SIZE + 1) / 2;
  localparam int FIW   = $clog2(FHALF + 1) > 0 ? $clog2(FHALF + 1) : 1;
  localparam int EIW   = $clog2(EHALF + 1) > 0 ? $clog2(EHALF + 1) : 1;
  localparam int QW    = 4 + 2 * FIW + 2 * EIW + 16 + 16 + 16 + 2;

  logic [3:0]    frames_r, frames_nxt;
  logic [6:0]    nf;
  logic [QW-1:0] q_word, q_head;
  logic          q_full, q_nonempty, q_pop;

  always_comb begin
    frames_nxt = (cfg_valid && cfg_ready) ? cfg_data : frames_r;
    if (frames_r == 4'd0) begin
      nf = 7'd1;
    end else if (32'(frames_r) > MAX_FRAMES) begin
      nf = 7'(MAX_FRAMES);
    end else begin
      nf = 7'(frames_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= 4'd2;
    end else begin
      frames_r <= frames_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;

  wms_front #(
    .TABLE_SIZE(TABLE_SIZE), .MAX_FRAMES(MAX_FRAMES), .FIW(FIW), .EIW(EIW), .QW(QW)
  ) u_front (
    .op          (in_tuser),
    .frame_sel   (in_tdata[2:0]),
    .entry_sel   (in_tdata[12:3]),
    .entry_value (in_tdata[28:13]),
    .sample_in   (in_tdata[44:29]),
    .morph       (in_tdata[61:45]),
    .nf          (nf),
    .q_word      (q_word)
  );

  wms_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_data (q_word),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  wms_back #(
    .TABLE_SIZE(TABLE_SIZE), .MAX_FRAMES(MAX_FRAMES), .FIW(FIW), .EIW(EIW), .QW(QW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[tb/tb.sv]
// self-checking bench for wavetable_morph_shaper: curve loads, shape beats, frame count changes
// depends on wms_pkg and the design top; the curve bank predictor and scoreboard live here
module tb;

  localparam int TSIZE = 1024;
  localparam int NFRM  = 8;
  localparam int WDOG_LIMIT = 20000;
  // shape beats only touch three entry windows, all of them loaded up front
  localparam int WIN    = 16;
  localparam int MID_LO = TSIZE / 2 - 8;
  localparam int USTEP  = 65536 / TSIZE;

  class shape_board;
    logic signed [15:0] bank [NFRM*TSIZE];
    logic [3:0] frame_count;
    logic signed [15:0] pending [$];
    int errors;

    function new();
      frame_count = 4'd2;
      errors = 0;
      foreach (bank[i]) bank[i] = '0;
    endfunction

    function logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                       logic [31:0] f);
      longint prod;
      prod = longint'(b - a) * longint'(f);
      return a + 32'(prod / 65536);
    endfunction

    function logic signed [31:0] frame_pt(int flo, int ff, bit pair, int e);
      logic signed [31:0] a;
      a = bank[flo*TSIZE + e];
      if (!pair) return a;
      return blend(a, bank[(flo+1)*TSIZE + e], ff);
    endfunction

    function void note_beat(logic op, logic [63:0] d);
      int nf, top, flo, ff, elo, ef;
      longint m, p, q;
      bit fpair, epair;
      logic signed [31:0] lo, hi, res;
      if (op == wms_pkg::OP_WRITE) begin
        bank[int'(d[2:0])*TSIZE + int'(d[12:3])] = d[28:13];
        return;
      end
      nf = frame_count;
      if (nf < 1) nf = 1;
      if (nf > NFRM) nf = NFRM;
      top = nf - 1;
      m = d[61:45];
      if (m > 65536) m = 65536;
      p = m * top;
      flo = int'(p >> 16);
      ff = int'(p & 16'hFFFF);
      fpair = 1;
      if (flo >= top) begin
        flo = top;
        fpair = 0;
      end
      q = longint'(int'($signed(d[44:29])) + 32768) * TSIZE;
      elo = int'(q >> 16);
      ef = int'(q & 16'hFFFF);
      epair = 1;
      if (elo >= TSIZE-1) begin
        elo = TSIZE-1;
        epair = 0;
      end
      lo = frame_pt(flo, ff, fpair, elo);
      res = lo;
      if (epair) begin
        hi = frame_pt(flo, ff, fpair, elo+1);
        res = blend(lo, hi, ef);
      end
      pending.insert(pending.size(), res[15:0]);
    endfunction

    task report(string msg);
      $display("%s", msg);
      errors++;
    endtask

    task check_result(logic [15:0] got);
      logic signed [15:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        report($sformatf("sample_out got %h want %h", got, want));
      end
    endtask
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [63:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [15:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [3:0] cfg_data;

  shape_board sb;
  int send_idle, recv_idle;
  bit hold_recv;
  int quiet;

  wavetable_morph_shaper #(.TABLE_SIZE(TSIZE), .MAX_FRAMES(NFRM)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (out_tvalid && out_tready && rst_n) sb.check_result(out_tdata);
    out_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays up between back-to-back beats and drops only while idling
  task automatic send_beat(logic op, logic [63:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(op, d);
  endtask

  function automatic logic [63:0] pack_wr(int f, int e, logic [15:0] v);
    return {2'b0, 17'd0, 16'd0, v, 10'(e), 3'(f)};
  endfunction

  function automatic logic [63:0] pack_sh(logic [15:0] s, logic [16:0] m);
    logic [63:0] d;
    d = {2'b0, m, s, 16'(0), 10'(0), 3'(0)};
    d[28:0] = 29'($urandom()); // ignored fields still toggle
    return d;
  endfunction

  function automatic int win_lo(int k);
    return (k == 0) ? 0 : (k == 1) ? MID_LO : TSIZE - WIN;
  endfunction

  // sample whose entry pair falls inside a loaded window
  function automatic logic [15:0] rand_sample();
    int u;
    if ($urandom_range(7) == 0)
      u = 65535 - int'($urandom_range(USTEP - 1));
    else
      u = win_lo(int'($urandom_range(2))) * USTEP + int'($urandom_range((WIN-1)*USTEP - 1));
    return 16'(u) ^ 16'h8000;
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frames(logic [3:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.frame_count = v;
    cfg_valid <= 1'b0;
  endtask

  // random curve data in every window of every frame so every read hits a written entry
  task automatic load_bank();
    for (int f = 0; f < NFRM; f++)
      for (int w = 0; w < 3; w++)
        for (int e = 0; e < WIN; e++)
          send_beat(wms_pkg::OP_WRITE, pack_wr(f, win_lo(w) + e, 16'($urandom())));
  endtask

  function automatic logic [16:0] rand_morph();
    case ($urandom_range(5))
      0: return 17'd65536;
      1: return 17'($urandom_range(131071, 65537));
      2: return 17'd0;
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_beat(wms_pkg::OP_WRITE,
                  pack_wr($urandom_range(7),
                          win_lo(int'($urandom_range(2))) + int'($urandom_range(WIN-1)),
                          16'($urandom())));
      else
        send_beat(wms_pkg::OP_SHAPE, pack_sh(rand_sample(), rand_morph()));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0; in_tvalid = 0; in_tuser = 0; in_tdata = '0;
    out_tready = 0; cfg_valid = 0; cfg_data = '0;
    hold_recv = 0; quiet = 0;
    send_idle = 0; recv_idle = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_bank();
    // directed: sample and morph extremes, reset frame count, then frame counts 0, 15, 8, 1
    send_beat(wms_pkg::OP_WRITE, pack_wr(7, 1023, 16'h7FFF));
    send_beat(wms_pkg::OP_WRITE, pack_wr(0, 0, 16'h8000));
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'h8000, 17'd0));
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'h7FFF, 17'd65536));
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'h7FC0, 17'd32768));
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'h0000, 17'h1FFFF));
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'hFFFF, 17'd65535));
    set_frames(4'd0);
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'h0123, 17'd40000));
    set_frames(4'd15);
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'h8123, 17'd65536));
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'h7C55, 17'd30000));
    set_frames(4'd8);
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'h8000, 17'd65535));
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'h7FFF, 17'd1));
    set_frames(4'd1);
    send_beat(wms_pkg::OP_SHAPE, pack_sh(16'hFE10, 17'd50000));

    send_idle = 12; recv_idle = 49;
    set_frames(4'd3);
    random_phase(320);
    // long receiver hold-off while the sender keeps going
    fork
      begin
        hold_recv = 1;
        repeat (200) @(posedge clk);
        hold_recv = 0;
      end
      random_phase(60);
    join
    drain();
    send_idle = 49; recv_idle = 12;
    set_frames(4'd8);
    random_phase(320);
    send_idle = 0; recv_idle = 0;
    set_frames(4'd5);
    random_phase(320);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
